// File: hw/rtl/multichannel_apb_down_timer_assert.svh
// Assertion macros shared by the down-timer RTL.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef MULTICHANNEL_APB_DOWN_TIMER_ASSERT_SVH
`define MULTICHANNEL_APB_DOWN_TIMER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MCDT_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define MCDT_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: hw/rtl/mcdt_pkg.sv
// Types and constants of the multichannel down timer.
// No dependencies; imported by mcdt_channel and the top level.
`timescale 1ns / 1ps

package mcdt_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam int unsigned CH_STRIDE = 20;
  localparam logic [31:0] VERSION_WORD = 32'h0000_0000;
  localparam logic [31:0] TMR_MAX = 32'hFFFF_FFFF;

  // Control word bits
  localparam int CTL_EN_BIT = 0;
  localparam int CTL_PERIODIC_BIT = 1;
  localparam int CTL_MASK_BIT = 2;
  localparam int CTL_W = 3;

  // Register offsets inside one channel window
  localparam logic [4:0] REG_LOAD  = 5'h00;
  localparam logic [4:0] REG_COUNT = 5'h04;
  localparam logic [4:0] REG_CTRL  = 5'h08;
  localparam logic [4:0] REG_EOI   = 5'h0c;
  localparam logic [4:0] REG_STAT  = 5'h10;

  // Global registers
  localparam logic [7:0] OFS_GSTAT = 8'ha0;
  localparam logic [7:0] OFS_GEOI  = 8'ha4;
  localparam logic [7:0] OFS_RAW   = 8'ha8;
  localparam logic [7:0] OFS_VER   = 8'hac;

  localparam int IRQ_W = 8;

  typedef struct packed {
    logic        tick;
    logic        wr_load;
    logic        wr_ctrl;
    logic        clr_pend;
    logic [31:0] wdata;
  } chan_cmd_t;

  typedef struct packed {
    logic [31:0]      load;
    logic [31:0]      count;
    logic [CTL_W-1:0] ctrl;
    logic             pend;
    logic             irq_nxt;
  } chan_stat_t;

endpackage

// File: hw/rtl/mcdt_channel.sv
// One timer channel: load count, counter, control word and raw pending bit.
// Depends on mcdt_pkg and multichannel_apb_down_timer_assert.svh.
`timescale 1ns / 1ps
`include "multichannel_apb_down_timer_assert.svh"

module mcdt_channel (
  input  logic               clk,
  input  logic               rst_n,
  input  mcdt_pkg::chan_cmd_t cmd,
  output mcdt_pkg::chan_stat_t stat
);
  import mcdt_pkg::*;

  logic [31:0]      load_r, load_nxt;
  logic [31:0]      count_r, count_nxt;
  logic [CTL_W-1:0] ctrl_r, ctrl_nxt;
  logic             pend_r, pend_nxt;

  always_comb begin
    load_nxt  = load_r;
    count_nxt = count_r;
    ctrl_nxt  = ctrl_r;
    pend_nxt  = pend_r;
    if (cmd.tick && ctrl_r[CTL_EN_BIT]) begin
      if (count_r == 32'd0) begin
        count_nxt = ctrl_r[CTL_PERIODIC_BIT] ? load_r : TMR_MAX;
        pend_nxt  = 1'b1;
      end else begin
        count_nxt = count_r - 32'd1;
      end
    end
    if (cmd.wr_load) begin
      load_nxt = cmd.wdata;
    end
    if (cmd.wr_ctrl) begin
      // enable rising loads the counter
      if (cmd.wdata[CTL_EN_BIT] && !ctrl_r[CTL_EN_BIT]) begin
        count_nxt = load_r;
      end
      ctrl_nxt = cmd.wdata[CTL_W-1:0];
    end
    if (cmd.clr_pend) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r  <= '0;
      count_r <= '0;
      ctrl_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      load_r  <= load_nxt;
      count_r <= count_nxt;
      ctrl_r  <= ctrl_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign stat.load    = load_r;
  assign stat.count   = count_r;
  assign stat.ctrl    = ctrl_r;
  assign stat.pend    = pend_r;
  assign stat.irq_nxt = pend_nxt && !ctrl_nxt[CTL_MASK_BIT];

  `MCDT_ASSERT_NEXT(a_enable_loads, cmd.wr_ctrl && cmd.wdata[CTL_EN_BIT] && !ctrl_r[CTL_EN_BIT], count_r == $past(load_r), "enable did not load counter")
  `MCDT_ASSERT_NEXT(a_zero_sets_pend, cmd.tick && ctrl_r[CTL_EN_BIT] && count_r == 32'd0 && !cmd.clr_pend, pend_r, "expiry did not set pending")
  `MCDT_ASSERT_NEXT(a_idle_holds, !ctrl_r[CTL_EN_BIT] && !cmd.wr_ctrl, $stable(count_r), "disabled counter moved")

endmodule

// File: hw/rtl/multichannel_apb_down_timer.sv
// Top level of the multichannel down timer: beat registers, decode, read mux.
// Depends on mcdt_pkg, mcdt_channel and multichannel_apb_down_timer_assert.svh.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid in_stall in_opcode in_offset      | sink
//           | in_write_data                              |
//   out     | out_valid out_stall out_read_data          | source
//           | out_irq_lines out_access_error             |
//
// A beat is accepted into the input register, where decode, the read mux and the channel
// update settle, and the result register takes its result once the result side is free.
// One beat is accepted every cycle while in_stall is low.
// Synchronous active-low reset clears all timer state and both pipeline valids.
// A stall on the result side holds the result register and, once the input register
// is also full, raises in_stall.
`timescale 1ns / 1ps
`include "multichannel_apb_down_timer_assert.svh"

module multichannel_apb_down_timer #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_offset,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic [7:0]  out_irq_lines,
  output logic        out_access_error
);
  import mcdt_pkg::*;

  localparam int unsigned REGION_END = NUM_CHANNELS * CH_STRIDE;
  localparam logic [IRQ_W-1:0] CH_MASK = IRQ_W'((1 << NUM_CHANNELS) - 1);

  // Input register: hold one beat while the result side is stalled
  logic        a_valid_r, a_valid_nxt;
  op_t         a_opcode_r;
  logic [7:0]  a_offset_r;
  logic [31:0] a_wdata_r;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_read_data_r, rdata_nxt;
  logic [IRQ_W-1:0] out_irq_lines_r, irq_nxt;
  logic             out_access_error_r, err_nxt;

  logic fire;
  logic in_acc;

  assign fire     = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !fire;
  assign in_acc   = in_valid && !in_stall;

  assign a_valid_nxt   = in_acc ? 1'b1 : (fire ? 1'b0 : a_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_opcode_r <= op_t'(in_opcode);
      a_offset_r <= in_offset;
      a_wdata_r  <= in_write_data;
    end
    if (fire) begin
      out_read_data_r    <= rdata_nxt;
      out_irq_lines_r    <= irq_nxt;
      out_access_error_r <= err_nxt;
    end
  end

  // Address decode
  logic [3:0] ofs_chan;
  logic [4:0] ofs_reg;
  logic       aligned;
  logic       in_region;
  logic       is_read;
  logic       is_write;
  logic       is_access;
  logic       geoi_hit;

  // Split the offset into channel and register by comparing against each
  // channel base; the highest base not above the offset wins.
  always_comb begin
    ofs_chan = '0;
    ofs_reg  = a_offset_r[4:0];
    for (int i = 1; i < NUM_CHANNELS; i++) begin
      if (a_offset_r >= 8'(i * CH_STRIDE)) begin
        ofs_chan = 4'(i);
        ofs_reg  = 5'(a_offset_r - 8'(i * CH_STRIDE));
      end
    end
  end

  assign aligned   = (a_offset_r[1:0] == 2'b00);
  assign in_region = aligned && (32'(a_offset_r) < REGION_END);
  assign is_read   = (a_opcode_r == OP_READ);
  assign is_write  = (a_opcode_r == OP_WRITE);
  assign is_access = a_opcode_r inside {OP_READ, OP_WRITE};
  assign geoi_hit  = aligned && !in_region && (a_offset_r == OFS_GEOI);

  chan_cmd_t  cmd  [NUM_CHANNELS];
  chan_stat_t stat [NUM_CHANNELS];

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
    logic sel;
    assign sel = in_region && (ofs_chan == 4'(i));
    assign cmd[i].tick     = fire && (a_opcode_r == OP_TICK);
    assign cmd[i].wr_load  = fire && is_write && sel && (ofs_reg == REG_LOAD);
    assign cmd[i].wr_ctrl  = fire && is_write && sel && (ofs_reg == REG_CTRL);
    assign cmd[i].clr_pend = fire && is_read && ((sel && (ofs_reg == REG_EOI)) || geoi_hit);
    assign cmd[i].wdata    = a_wdata_r;

    mcdt_channel u_ch (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (cmd[i]),
      .stat (stat[i])
    );
  end

  // Gather vectors and the selected channel's registers
  logic [IRQ_W-1:0] raw_vec;
  logic [IRQ_W-1:0] msk_vec;
  chan_stat_t       sel_stat;

  always_comb begin
    raw_vec  = '0;
    msk_vec  = '0;
    irq_nxt  = '0;
    sel_stat = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      raw_vec[i] = stat[i].pend;
      msk_vec[i] = stat[i].pend && !stat[i].ctrl[CTL_MASK_BIT];
      irq_nxt[i] = stat[i].irq_nxt;
      if (ofs_chan == 4'(i)) begin
        sel_stat = sel_stat | stat[i];
      end
    end
  end

  // Read data and error for the beat in the input register
  logic [31:0] rd_val;
  logic        mapped;
  logic        ro_reg;

  always_comb begin
    rd_val = '0;
    mapped = 1'b0;
    ro_reg = 1'b0;
    if (in_region) begin
      case (ofs_reg)
        REG_LOAD: begin
          mapped = 1'b1;
          rd_val = sel_stat.load;
        end
        REG_COUNT: begin
          mapped = 1'b1;
          ro_reg = 1'b1;
          rd_val = sel_stat.count;
        end
        REG_CTRL: begin
          mapped = 1'b1;
          rd_val = 32'(sel_stat.ctrl);
        end
        REG_EOI: begin
          mapped = 1'b1;
          ro_reg = 1'b1;
        end
        REG_STAT: begin
          mapped = 1'b1;
          ro_reg = 1'b1;
          rd_val = 32'(sel_stat.pend && !sel_stat.ctrl[CTL_MASK_BIT]);
        end
        default: begin
          mapped = 1'b0;
        end
      endcase
    end else if (aligned) begin
      case (a_offset_r)
        OFS_GSTAT: begin
          mapped = 1'b1;
          ro_reg = 1'b1;
          rd_val = 32'(msk_vec);
        end
        OFS_GEOI: begin
          mapped = 1'b1;
          ro_reg = 1'b1;
        end
        OFS_RAW: begin
          mapped = 1'b1;
          ro_reg = 1'b1;
          rd_val = 32'(raw_vec);
        end
        OFS_VER: begin
          mapped = 1'b1;
          ro_reg = 1'b1;
          rd_val = VERSION_WORD;
        end
        default: begin
          mapped = 1'b0;
        end
      endcase
    end
  end

  // Drop the read value on writes and errors; ticks and no-ops give zero
  assign rdata_nxt = (is_read && mapped) ? rd_val : 32'd0;
  assign err_nxt   = is_access && (!mapped || (is_write && ro_reg));

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_irq_lines    = out_irq_lines_r;
  assign out_access_error = out_access_error_r;

  `MCDT_ASSERT_NOW(a_no_stall_empty, !a_valid_r, !in_stall, "stall raised with empty input register")
  `MCDT_ASSERT_NEXT(a_tick_quiet, fire && a_opcode_r == OP_TICK, out_read_data_r == 32'd0 && !out_access_error_r, "tick gave data or error")
  `MCDT_ASSERT_NOW(a_err_zero_data, out_valid_r && out_access_error_r, out_read_data_r == 32'd0, "error beat carries data")
  `MCDT_ASSERT_NOW(a_irq_range, out_valid_r, (out_irq_lines_r & ~CH_MASK) == '0, "interrupt on absent channel")

endmodule
